@@ rtl/core/fmob_pkg.sv @@
// ----------------------------------------------------------------------------
// fmob_pkg
// Shared widths, codes and the operation record that the front end hands
// to the back end of the frame mean-offset binarizer.
// ----------------------------------------------------------------------------
package fmob_pkg;

   localparam int unsigned PIX_W   = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned SUM_W   = 23;
   localparam int unsigned THR_W   = 10;

   localparam int unsigned MAX_PIXELS_DEFAULT = 32768;

   // The queue depth must stay a power of two: the pointers wrap naturally.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned DIV_STEP_W = $clog2(SUM_W);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [PIX_W-1:0] LEVEL_BELOW = 8'd254;
   localparam logic [PIX_W-1:0] LEVEL_ABOVE = 8'd0;
   localparam logic [PIX_W-1:0] MIN_RESET   = 8'd255;

   typedef struct packed {
      logic               is_read;
      logic               first_read;
      logic               last;
      logic [COUNT_W-1:0] addr;
      logic [PIX_W-1:0]   pixel;
      logic [SUM_W-1:0]   sum;
      logic [PIX_W-1:0]   min_val;
      logic [COUNT_W-1:0] count;
   } fmob_op_type;

endpackage

@@ rtl/core/fmob_front.sv @@
// ----------------------------------------------------------------------------
// fmob_front
// Command front end: keeps the frame statistics and the read pointer,
// classifies each command and queues the work for the back end.
// ----------------------------------------------------------------------------
module fmob_front #(
   parameter int unsigned MAX_PIXELS = fmob_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           cmd,
   input  logic [fmob_pkg::PIX_W-1:0]     pixel_in,
   output logic                           push,
   output fmob_pkg::fmob_op_type          op
);
   import fmob_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PIXELS);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PIX_W-1:0]   min_ff, min_in;
   logic [COUNT_W-1:0] rp_ff, rp_in;
   logic               reading_ff, reading_in;

   logic [COUNT_W-1:0] count_base;
   logic [SUM_W-1:0]   sum_base;
   logic [PIX_W-1:0]   min_base;
   logic [COUNT_W-1:0] rp_base;

   always_comb begin
      // A load during read-out starts a new frame from empty statistics.
      count_base = reading_ff ? '0 : count_ff;
      sum_base   = reading_ff ? '0 : sum_ff;
      min_base   = reading_ff ? MIN_RESET : min_ff;
      rp_base    = reading_ff ? rp_ff : '0;

      count_in   = count_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      rp_in      = rp_ff;
      reading_in = reading_ff;
      push       = 1'b0;
      op         = '0;

      if (accept) begin
         if (cmd == CMD_LOAD) begin
            reading_in = 1'b0;
            count_in   = count_base;
            sum_in     = sum_base;
            min_in     = min_base;
            rp_in      = reading_ff ? '0 : rp_ff;
            if (count_base < MAX_COUNT) begin
               push       = 1'b1;
               op.addr    = count_base;
               op.pixel   = pixel_in;
               sum_in     = sum_base + SUM_W'(pixel_in);
               min_in     = (pixel_in < min_base) ? pixel_in : min_base;
               count_in   = count_base + 1'b1;
            end
         end else if (count_ff != '0) begin
            reading_in = 1'b1;
            rp_in      = rp_base;
            if (rp_base < count_ff) begin
               push          = 1'b1;
               op.is_read    = 1'b1;
               op.first_read = !reading_ff;
               op.addr       = rp_base;
               op.last       = ((rp_base + 1'b1) == count_ff);
               op.sum        = sum_ff;
               op.min_val    = min_ff;
               op.count      = count_ff;
               rp_in         = rp_base + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_ff     <= '0;
         min_ff     <= MIN_RESET;
         rp_ff      <= '0;
         reading_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         rp_ff      <= rp_in;
         reading_ff <= reading_in;
      end
   end

endmodule

@@ rtl/core/fmob_queue.sv @@
// ----------------------------------------------------------------------------
// fmob_queue
// Small first-in first-out queue of operations between front and back end.
// ----------------------------------------------------------------------------
module fmob_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fmob_pkg::fmob_op_type push_op,
   input  logic                  pop,
   output logic                  head_valid,
   output fmob_pkg::fmob_op_type head_op,
   output logic                  full
);
   import fmob_pkg::*;

   fmob_op_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   assign head_valid = (fill_ff != '0);
   assign full       = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ rtl/core/fmob_back.sv @@
// ----------------------------------------------------------------------------
// fmob_back
// Execution back end: frame memory, bit-serial mean divider, threshold
// register and the registered result outputs.
// ----------------------------------------------------------------------------
module fmob_back #(
   parameter int unsigned MAX_PIXELS = fmob_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  fmob_pkg::fmob_op_type       op,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [fmob_pkg::PIX_W-1:0]  rsp_pixel_out,
   output logic                        rsp_last_pixel
);
   import fmob_pkg::*;

   localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_THR  = 2'd2;
   localparam logic [1:0] ST_CMP  = 2'd3;

   logic [PIX_W-1:0] mem [MAX_PIXELS];

   logic [1:0]            state_ff, state_in;
   logic [COUNT_W-1:0]    div_ff, div_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [PIX_W-1:0]      min_ff, min_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  last_ff, last_in;
   logic [THR_W-1:0]      thr_ff, thr_in;
   logic [PIX_W-1:0]      rd_data_ff;
   logic                  strobe_ff, strobe_in;
   logic [PIX_W-1:0]      pix_out_ff, pix_out_in;
   logic                  last_out_ff;

   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [COUNT_W:0]      trial;
   logic [COUNT_W:0]      diff;
   logic                  trial_ge;

   assign rsp_strobe     = strobe_ff;
   assign rsp_pixel_out  = pix_out_ff;
   assign rsp_last_pixel = last_out_ff;

   always_comb begin
      // Restoring division, one quotient bit per cycle; the dividend shifts
      // out of the top of quo_ff while quotient bits enter at the bottom.
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      diff     = trial - {1'b0, div_ff};
      trial_ge = (trial >= {1'b0, div_ff});

      pop         = (state_ff == ST_IDLE) && op_valid;
      mem_wr_en   = pop && !op.is_read;
      mem_rd_en   = (pop && op.is_read && !op.first_read) || (state_ff == ST_THR);
      mem_rd_addr = (state_ff == ST_THR) ? addr_ff : op.addr[ADDR_W-1:0];

      state_in = state_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      min_in   = min_ff;
      addr_in  = addr_ff;
      last_in  = last_ff;
      thr_in   = thr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop && op.is_read) begin
               addr_in = op.addr[ADDR_W-1:0];
               last_in = op.last;
               if (op.first_read) begin
                  div_in   = op.count;
                  rem_in   = '0;
                  quo_in   = op.sum;
                  min_in   = op.min_val;
                  step_in  = DIV_STEP_W'(SUM_W - 1);
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_THR;
            end
         end
         ST_THR: begin
            thr_in   = THR_W'(min_ff) + quo_ff[THR_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      strobe_in  = (state_ff == ST_CMP);
      pix_out_in = (THR_W'(rd_data_ff) < thr_ff) ? LEVEL_BELOW : LEVEL_ABOVE;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[op.addr[ADDR_W-1:0]] <= op.pixel;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      min_ff  <= min_in;
      addr_ff <= addr_in;
      last_ff <= last_in;
      if (state_ff == ST_CMP) begin
         pix_out_ff  <= pix_out_in;
         last_out_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         thr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         thr_ff    <= thr_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

@@ rtl/core/frame_mean_offset_binarizer.sv @@
// ----------------------------------------------------------------------------
// frame_mean_offset_binarizer
// Stores a grayscale frame, then binarizes it on read-out against the frame
// minimum plus the truncated mean.
//
//   Channel   Ports                                Direction  Transfer
//   request   start, busy, req_cmd, req_pixel_in   in         start & !busy
//   response  rsp_strobe, rsp_pixel_out,           out        rsp_strobe
//             rsp_last_pixel
//
// A load leaves the back end idle, so pixels stream in at one per cycle
// while busy is low. A read holds the back end through the ST_CMP state;
// its strobe follows its transfer through the queue entry, ST_CMP and the
// strobe register. The first read of a frame also runs the mean divider,
// one quotient bit per cycle, and the ST_THR step before ST_CMP. busy rises
// while the four-entry command queue is full. Reset clears control state
// only; the frame memory is not cleared. The response side cannot stall.
// ----------------------------------------------------------------------------
module frame_mean_offset_binarizer #(
   parameter int unsigned MAX_PIXELS = fmob_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [fmob_pkg::PIX_W-1:0]  req_pixel_in,
   output logic                        rsp_strobe,
   output logic [fmob_pkg::PIX_W-1:0]  rsp_pixel_out,
   output logic                        rsp_last_pixel
);
   import fmob_pkg::*;

   logic        accept;
   logic        q_push;
   logic        q_pop;
   logic        q_valid;
   logic        q_full;
   fmob_op_type push_op;
   fmob_op_type head_op;

   assign busy   = q_full;
   assign accept = start && !busy;

   fmob_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_cmd),
      .pixel_in (req_pixel_in),
      .push     (q_push),
      .op       (push_op)
   );

   fmob_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (push_op),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (head_op),
      .full       (q_full)
   );

   fmob_back #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (q_valid),
      .op             (head_op),
      .pop            (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // Every read passes through ST_CMP before the back end returns to idle, so strobes never touch.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobes in consecutive cycles");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("operation queued while the queue is full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("operation taken from an empty queue");

   // A result never appears in the cycle after the back end took a load.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !head_op.is_read) |=> !rsp_strobe)
      else $error("result follows a load");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_mean_offset_binarizer. A queue of pixel loads
// and read-out commands is driven with random gaps; every accepted command
// runs through a local copy of the frame store, sum, minimum and threshold,
// and each response is matched against the oldest expected pixel.
// ----------------------------------------------------------------------------
module tb;
   import fmob_pkg::*;

   localparam int unsigned FRAME_CAP = MAX_PIXELS_DEFAULT;
   localparam int unsigned DRAIN_CYC = 64;

   typedef struct {
      logic             cmd;
      logic [PIX_W-1:0] pixel;
      bit               hold;
   } pixel_cmd_type;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             last;
      longint unsigned  accepted_at;
   } bin_pixel_type;

   logic             clock;
   logic             reset;
   logic             start = 1'b0;
   logic             req_cmd = CMD_LOAD;
   logic [PIX_W-1:0] req_pixel_in = '0;
   logic             busy;
   logic             rsp_strobe;
   logic [PIX_W-1:0] rsp_pixel_out;
   logic             rsp_last_pixel;

   frame_mean_offset_binarizer u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_pixel_in   (req_pixel_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_pixel (rsp_last_pixel)
   );

   pixel_cmd_type pending_cmds[$];
   bin_pixel_type expected_pixels[$];

   // Local copy of the frame state.
   logic [PIX_W-1:0]   frame_pixels [FRAME_CAP];
   logic [COUNT_W-1:0] loaded;
   logic [SUM_W-1:0]   level_sum;
   logic [PIX_W-1:0]   level_min;
   logic [THR_W-1:0]   cut_level;
   logic [COUNT_W-1:0] next_read;
   bit                 in_readout;

   int unsigned sent_count;
   int          results_in_flight;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned cycle_limit = 32'hFFFF_FFFF;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit binarize_step(input logic cmd, input logic [PIX_W-1:0] pix,
                                        output bin_pixel_type res);
      res.pixel = LEVEL_ABOVE;
      res.last = 1'b0;
      res.accepted_at = 0;
      if (cmd == CMD_LOAD) begin
         // A load during read-out opens a new frame.
         if (in_readout) begin
            loaded = '0;
            level_sum = '0;
            level_min = MIN_RESET;
            next_read = '0;
            in_readout = 1'b0;
         end
         if (loaded < FRAME_CAP) begin
            frame_pixels[loaded] = pix;
            level_sum = level_sum + pix;
            if (pix < level_min)
               level_min = pix;
            loaded = loaded + 1'b1;
         end
         return 1'b0;
      end
      if (loaded == 0)
         return 1'b0;
      if (!in_readout) begin
         cut_level = THR_W'(level_min + level_sum / loaded);
         next_read = '0;
         in_readout = 1'b1;
      end
      if (next_read >= loaded)
         return 1'b0;
      res.pixel = (frame_pixels[next_read] < cut_level) ? LEVEL_BELOW : LEVEL_ABOVE;
      res.last = (next_read + 1 == loaded);
      next_read = next_read + 1'b1;
      return 1'b1;
   endfunction

   function automatic void flag_error(input string what);
      error_count++;
      if (error_count <= 10)
         $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   task automatic add_item(input logic cmd, input int unsigned pix, input bit hold);
      pixel_cmd_type item;
      item.cmd = cmd;
      item.pixel = PIX_W'(pix);
      item.hold = hold;
      pending_cmds.push_back(item);
   endtask

   // One frame of loads with a random value profile, then a run of reads.
   task automatic queue_frame(input int unsigned size, input int unsigned reads,
                              input bit hold);
      int unsigned style;
      int          base;
      int          pix;
      style = $urandom_range(3);
      base = $urandom_range(255);
      for (int i = 0; i < size; i++) begin
         case (style)
            0: pix = $urandom_range(255);
            1: begin
               pix = base + $urandom_range(16) - 8;
               if (pix < 0) pix = 0;
               if (pix > 255) pix = 255;
            end
            2: pix = base;
            default: pix = $urandom_range(1) ? 255 : 0;
         endcase
         add_item(CMD_LOAD, pix, hold && i == 0);
      end
      repeat (reads) add_item(CMD_READ, $urandom_range(255), 1'b0);
   endtask

   // Driver: one transfer per edge at most, the next command picked at the same edge.
   always @(posedge clock) begin
      pixel_cmd_type nxt;
      bin_pixel_type pred;
      if (reset) begin
         start <= 1'b0;
         req_cmd <= CMD_LOAD;
         req_pixel_in <= '0;
      end else begin
         if (start && !busy) begin
            sent_count++;
            if (binarize_step(req_cmd, req_pixel_in, pred)) begin
               pred.accepted_at = $time;
               expected_pixels.push_back(pred);
               results_in_flight++;
            end
         end
         if (rsp_strobe)
            results_in_flight--;
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_cmds.size() != 0
                      && !(pending_cmds[0].hold && results_in_flight != 0)
                      && !((sent_count < 300 || sent_count >= 700)
                           && $urandom_range(99) < 27)) begin
            nxt = pending_cmds.pop_front();
            start <= 1'b1;
            req_cmd <= nxt.cmd;
            req_pixel_in <= nxt.pixel;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results are taken at the edge that ends their strobe cycle.
   always @(posedge clock) begin
      bin_pixel_type want;
      if (!reset && rsp_strobe) begin
         if (expected_pixels.size() == 0 || expected_pixels[0].accepted_at == $time) begin
            flag_error($sformatf("unexpected result pixel_out=%0d last_pixel=%0d",
                                 rsp_pixel_out, rsp_last_pixel));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel || rsp_last_pixel !== want.last)
               flag_error($sformatf("pixel_out exp %0d got %0d, last_pixel exp %0d got %0d",
                                    want.pixel, rsp_pixel_out, want.last, rsp_last_pixel));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= cycle_limit) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int unsigned size;
      int unsigned reads;
      int unsigned frame_no;
      int unsigned goal;

      reset = 1'b1;
      loaded = '0;
      level_sum = '0;
      level_min = MIN_RESET;
      cut_level = '0;
      next_read = '0;
      in_readout = 1'b0;

      // Reads before anything is stored give nothing.
      add_item(CMD_READ, 0, 1'b0);
      add_item(CMD_READ, 255, 1'b0);
      // Extremes: threshold 127 lands on a stored pixel; one read past the end.
      add_item(CMD_LOAD, 0, 1'b0);
      add_item(CMD_LOAD, 255, 1'b0);
      add_item(CMD_LOAD, 128, 1'b0);
      add_item(CMD_LOAD, 127, 1'b0);
      repeat (5) add_item(CMD_READ, 0, 1'b0);
      // Single-pixel frames at both ends of the range.
      add_item(CMD_LOAD, 255, 1'b0);
      repeat (2) add_item(CMD_READ, 0, 1'b0);
      add_item(CMD_LOAD, 0, 1'b0);
      add_item(CMD_READ, 0, 1'b0);
      // A load in the middle of a read-out starts a new frame.
      add_item(CMD_LOAD, 10, 1'b0);
      add_item(CMD_LOAD, 20, 1'b0);
      add_item(CMD_LOAD, 30, 1'b0);
      add_item(CMD_READ, 0, 1'b0);
      add_item(CMD_LOAD, 5, 1'b0);
      add_item(CMD_LOAD, 200, 1'b0);
      repeat (3) add_item(CMD_READ, 0, 1'b0);

      frame_no = 0;
      goal = pending_cmds.size() + 1200;
      while (pending_cmds.size() < goal) begin
         if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 6))
               add_item(1'($urandom_range(1)), $urandom_range(255), 1'b0);
         case ($urandom_range(19))
            0:       size = $urandom_range(1, 3);
            1, 2, 3: size = $urandom_range(25, 120);
            default: size = $urandom_range(1, 24);
         endcase
         case ($urandom_range(19))
            0, 1, 2: reads = $urandom_range(1, size);
            3, 4, 5: reads = size + $urandom_range(2, 4);
            default: reads = size + 1;
         endcase
         queue_frame(size, reads, frame_no == 2 || $urandom_range(11) == 0);
         frame_no++;
      end
      cycle_limit = pending_cmds.size() * 40 + 20000;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
      if (error_count == 0 && expected_pixels.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
